### rtl/adcar_pkg.sv
// ----------------------------------------------------------------------------
// adcar_pkg
// Shared types, register codes and range tables of the ADC auto-range monitor.
// ----------------------------------------------------------------------------
package adcar_pkg;

    // Field widths
    localparam int CODE_W   = 16;
    localparam int MAG_W    = 17;
    localparam int RANGE_W  = 3;
    localparam int UV_W     = 24;
    localparam int SCALED_W = 30;
    localparam int PROD_W   = 40;
    localparam int OV_W     = 13;
    localparam int DELAY_W  = 24;
    localparam int OVCNT_W  = 4;

    // Range limits and thresholds
    localparam logic [RANGE_W-1:0] MAX_RANGE  = 3'd5;
    localparam logic [OVCNT_W-1:0] OVER_LIMIT = 4'd10;
    // Widen when mag*20 > 19*32768, i.e. above 95% of full scale
    localparam logic [20:0]        WIDEN_LIM  = 21'd622592;

    // Register indexes (word address paddr[3:2])
    localparam logic [1:0] REG_AUTO  = 2'd0;
    localparam logic [1:0] REG_OVER  = 2'd1;
    localparam logic [1:0] REG_DELAY = 2'd2;

    // Register reset values
    localparam logic [OV_W-1:0]    OVER_RESET  = 13'd6144;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 24'd5000;

    typedef struct packed {
        logic               auto_en;
        logic [OV_W-1:0]    ov_mv;
        logic [DELAY_W-1:0] delay;
    } cfg_t;

    typedef struct packed {
        logic signed [UV_W-1:0] value_uv;
        logic [SCALED_W-1:0]    scaled;   // |value| in mV * 32768
        logic                   widen;
    } conv_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_index;
        logic               changed;
        logic               warn;
    } upd_t;

    // Full scale is 3*2^11 at range 0, else 2^(12-r+1); return the shift
    function automatic logic [3:0] fs_shift(input logic [RANGE_W-1:0] r);
        logic [3:0] s;
        case (r)
            3'd0:    s = 4'd11;
            3'd1:    s = 4'd12;
            3'd2:    s = 4'd11;
            3'd3:    s = 4'd10;
            3'd4:    s = 4'd9;
            default: s = 4'd8;
        endcase
        return s;
    endfunction

    // Full scale in microvolts
    function automatic logic [22:0] fs_uv(input logic [RANGE_W-1:0] r);
        logic [22:0] v;
        case (r)
            3'd0:    v = 23'd6144000;
            3'd1:    v = 23'd4096000;
            3'd2:    v = 23'd2048000;
            3'd3:    v = 23'd1024000;
            3'd4:    v = 23'd512000;
            default: v = 23'd256000;
        endcase
        return v;
    endfunction

    // 4 * fs[next narrower] * 32768, compared against scaled*5
    function automatic logic [29:0] quiet_lim(input logic [RANGE_W-1:0] r);
        logic [29:0] v;
        case (r)
            3'd0:    v = 30'd4096 << 17;
            3'd1:    v = 30'd2048 << 17;
            3'd2:    v = 30'd1024 << 17;
            3'd3:    v = 30'd512 << 17;
            default: v = 30'd256 << 17;
        endcase
        return v;
    endfunction

endpackage

### rtl/adcar_cfg_regs.sv
// ----------------------------------------------------------------------------
// adcar_cfg_regs
// APB register file: auto-range enable, overvoltage level, range-down delay.
// ----------------------------------------------------------------------------
module adcar_cfg_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output adcar_pkg::cfg_t     cfg
);
    import adcar_pkg::*;

    logic               auto_reg;
    logic [OV_W-1:0]    ov_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Write on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_reg  <= 1'b0;
            ov_reg    <= OVER_RESET;
            delay_reg <= DELAY_RESET;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_AUTO:  auto_reg  <= pwdata[0];
                REG_OVER:  ov_reg    <= pwdata[OV_W-1:0];
                REG_DELAY: delay_reg <= pwdata[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back, zero beyond the register list
    always_comb begin
        unique case (paddr[3:2])
            REG_AUTO:  prdata = {31'b0, auto_reg};
            REG_OVER:  prdata = {{(32-OV_W){1'b0}}, ov_reg};
            REG_DELAY: prdata = {{(32-DELAY_W){1'b0}}, delay_reg};
            default:   prdata = 32'b0;
        endcase
    end

    assign cfg.auto_en = auto_reg;
    assign cfg.ov_mv   = ov_reg;
    assign cfg.delay   = delay_reg;

endmodule

### rtl/adcar_convert.sv
// ----------------------------------------------------------------------------
// adcar_convert
// Code to microvolt conversion and full-scale magnitude for one sample.
// ----------------------------------------------------------------------------
module adcar_convert (
    input  logic [adcar_pkg::CODE_W-1:0]  code,
    input  logic [adcar_pkg::RANGE_W-1:0] range_cur,
    output adcar_pkg::conv_t              conv
);
    import adcar_pkg::*;

    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [MAG_W+1:0]  base;
    logic [SCALED_W-1:0] scaled;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] prod_rnd;
    logic [UV_W-1:0]   mag_uv;
    logic [20:0]       mag_x20;

    // Magnitude of the two's complement code, 0x8000 gives 32768
    assign neg = code[CODE_W-1];
    assign mag = neg ? (17'h10000 - {1'b0, code}) : {1'b0, code};

    // mag * fs in mV: times three for the widest range, then a shift
    assign base   = (range_cur == 3'd0) ? ({2'b0, mag} + {1'b0, mag, 1'b0}) : {2'b0, mag};
    assign scaled = SCALED_W'({11'b0, base} << fs_shift(range_cur));

    // Microvolts: floor for positive, ceiling of magnitude for negative
    assign prod     = {23'b0, mag} * {17'b0, fs_uv(range_cur)};
    assign prod_rnd = prod + (neg ? PROD_W'(32767) : PROD_W'(0));
    assign mag_uv   = prod_rnd[15 +: UV_W];

    // Above 95% of the current full scale
    assign mag_x20 = {mag, 4'b0} + {2'b0, mag, 2'b0};

    assign conv.value_uv = neg ? -$signed(mag_uv) : $signed(mag_uv);
    assign conv.scaled   = scaled;
    assign conv.widen    = mag_x20 > WIDEN_LIM;

endmodule

### rtl/adcar_chan_state.sv
// ----------------------------------------------------------------------------
// adcar_chan_state
// Per-channel range, quiet countdown and overvoltage counter with update.
// ----------------------------------------------------------------------------
module adcar_chan_state #(
    parameter int CHANNELS = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          update,
    input  logic [1:0]                    ch,
    input  adcar_pkg::cfg_t               cfg,
    input  adcar_pkg::conv_t              conv,
    output logic [adcar_pkg::RANGE_W-1:0] range_cur,
    output adcar_pkg::upd_t               upd
);
    import adcar_pkg::*;

    localparam int         IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [2:0] CH_LIM = 3'(CHANNELS);

    logic [RANGE_W-1:0] range_sel_reg [CHANNELS];
    logic [DELAY_W-1:0] quiet_cnt_reg [CHANNELS];
    logic [OVCNT_W-1:0] over_cnt_reg  [CHANNELS];

    logic               ch_ok;
    logic [IDX_W-1:0]   idx;
    logic [RANGE_W-1:0] sel_cur;
    logic [OVCNT_W-1:0] over_inc;
    logic               over_hit;
    logic [OVCNT_W-1:0] over_next;
    logic               warn;
    logic [DELAY_W-1:0] cnt_start;
    logic [DELAY_W-1:0] quiet_next;
    logic [RANGE_W-1:0] range_next;
    logic               changed;
    logic [32:0]        scaled_x5;
    logic               quiet;

    assign ch_ok   = {1'b0, ch} < CH_LIM;
    assign idx     = ch_ok ? ch[IDX_W-1:0] : '0;
    assign sel_cur = range_sel_reg[idx];

    // Clamp the stored range; channels out of range convert at the widest
    assign range_cur = !ch_ok ? 3'd0 : ((sel_cur > MAX_RANGE) ? MAX_RANGE : sel_cur);

    // Count overvoltage samples, warn and clear on the eleventh
    assign over_hit = conv.scaled > {2'b0, cfg.ov_mv, 15'b0};
    assign over_inc = over_cnt_reg[idx] + 4'd1;
    always_comb begin
        over_next = over_cnt_reg[idx];
        warn      = 1'b0;
        if (over_hit) begin
            if (over_inc > OVER_LIMIT) begin
                warn      = 1'b1;
                over_next = '0;
            end else begin
                over_next = over_inc;
            end
        end
    end

    // Range control: widen at once, narrow after the quiet countdown
    assign scaled_x5 = {3'b0, conv.scaled} + {1'b0, conv.scaled, 2'b0};
    assign cnt_start = (quiet_cnt_reg[idx] == '0) ? cfg.delay : quiet_cnt_reg[idx];
    always_comb begin
        range_next = range_cur;
        changed    = 1'b0;
        quiet_next = cnt_start;
        if (conv.widen && (range_cur != 3'd0)) begin
            range_next = range_cur - 3'd1;
            changed    = 1'b1;
        end
        quiet = (scaled_x5 < {3'b0, quiet_lim(range_next)}) && (range_next != MAX_RANGE);
        if (quiet) begin
            if (cnt_start <= 24'd1) begin
                range_next = range_next + 3'd1;
                changed    = 1'b1;
                quiet_next = '0;
            end else begin
                quiet_next = cnt_start - 24'd1;
            end
        end else begin
            quiet_next = cfg.delay;
        end
        if (!cfg.auto_en) begin
            range_next = range_cur;
            changed    = 1'b0;
        end
    end

    // Commit the channel state as the word leaves for the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                range_sel_reg[i] <= '0;
                quiet_cnt_reg[i] <= '0;
                over_cnt_reg[i]  <= '0;
            end
        end else if (update && ch_ok) begin
            over_cnt_reg[idx] <= over_next;
            if (cfg.auto_en) begin
                range_sel_reg[idx] <= range_next;
                quiet_cnt_reg[idx] <= quiet_next;
            end
        end
    end

    assign upd.range_index = ch_ok ? range_next : 3'd0;
    assign upd.changed     = ch_ok & changed;
    assign upd.warn        = ch_ok & warn;

endmodule

### rtl/adc_auto_range_monitor.sv
// ----------------------------------------------------------------------------
// adc_auto_range_monitor
// Per-channel ADC sample conditioner with microvolt conversion, overvoltage
// warning and automatic range switching.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_axis    in         tuser: channel, tdata: raw 16-bit code
//  m_axis    out        tuser: channel, tdata: uV, range, changed, warn
//  apb       in/out     three configuration registers at 0x0, 0x4, 0x8
//
//  One word per cycle sustained while m_axis does not stall; each word passes
//  through the input register, where conversion and the channel state update
//  happen, and then sits in the output register until taken.
//  Reset clears all channel state to the widest range with no clearing pass.
//  A stall on m_axis holds both registers; s_tready drops only when both
//  are full.
// ----------------------------------------------------------------------------
module adc_auto_range_monitor #(
    parameter int CHANNELS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_code
    input  logic [1:0]  s_tuser,   // [1:0] channel
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [23:0] value_uv, [26:24] range_index,
                                   // [27] range_changed, [28] overvoltage_warn
    output logic [1:0]  m_tuser,   // [1:0] out_channel
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import adcar_pkg::*;

    cfg_t  cfg;
    conv_t conv;
    upd_t  upd;

    logic                in_valid_reg;
    logic [1:0]          in_ch_reg;
    logic [CODE_W-1:0]   in_code_reg;
    logic                out_valid_reg;
    logic [1:0]          out_ch_reg;
    logic [UV_W-1:0]     out_uv_reg;
    logic [RANGE_W-1:0]  out_range_reg;
    logic                out_chg_reg;
    logic                out_warn_reg;
    logic                advance;
    logic [RANGE_W-1:0]  range_cur;

    adcar_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    adcar_convert u_conv (
        .code      (in_code_reg),
        .range_cur (range_cur),
        .conv      (conv)
    );

    adcar_chan_state #(
        .CHANNELS (CHANNELS)
    ) u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .update    (advance),
        .ch        (in_ch_reg),
        .cfg       (cfg),
        .conv      (conv),
        .range_cur (range_cur),
        .upd       (upd)
    );

    // Move the word on when the output register is empty or being taken
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_ch_reg   <= s_tuser;
            in_code_reg <= s_tdata;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_ch_reg    <= in_ch_reg;
            out_uv_reg    <= conv.value_uv;
            out_range_reg <= upd.range_index;
            out_chg_reg   <= upd.changed;
            out_warn_reg  <= upd.warn;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ch_reg;
    assign m_tdata  = {3'b0, out_warn_reg, out_chg_reg, out_range_reg, out_uv_reg};

endmodule

### test/adc_auto_range_monitor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_auto_range_monitor_tb
// Self-checking bench for the ADC auto-range monitor. Samples are fed from a
// queue through a stream driver with random gaps. A monitor with random
// stalls compares every result word field by field against a per-channel
// predictor of the conversion, the overvoltage counter and the range switch.
// Registers are written over the config port between phases while the
// block is idle.
// ----------------------------------------------------------------------------
module adc_auto_range_monitor_tb;
    import adcar_pkg::*;

    localparam int NUM_CH        = 4;
    localparam int NARROWEST     = 5;
    localparam int WARN_COUNT    = 10;
    localparam int GAP_MAX       = 14;
    localparam int IDLE_LIMIT    = 1000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_SAMPLES = 75;

    typedef struct packed {
        logic [1:0]  channel;
        logic [15:0] code;
    } sample_t;

    typedef struct packed {
        logic [1:0]  channel;
        logic [23:0] value_uv;
        logic [2:0]  range_index;
        logic        changed;
        logic        warn;
    } reading_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [15:0] sample_code
    logic [1:0]  s_tuser  = '0;    // [1:0] channel
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [23:0] value_uv, [26:24] range_index,
                                   // [27] range_changed, [28] overvoltage_warn
    logic [1:0]  m_tuser;          // [1:0] out_channel
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the registers and the per-channel state
    logic               cfg_auto;
    logic [OV_W-1:0]    cfg_ov_mv;
    logic [DELAY_W-1:0] cfg_delay;
    logic [2:0]         ch_range [NUM_CH];
    logic [23:0]        ch_quiet [NUM_CH];
    logic [3:0]         ch_over  [NUM_CH];

    sample_t  sample_queue[$];
    reading_t expected_readings[$];
    sample_t  cur_sample;
    reading_t want;
    logic     send_next;
    logic     send_no_idle  = 1'b0;
    logic     recv_no_stall = 1'b0;
    int       send_wait;
    int       recv_wait;
    int       idle_cycles   = 0;
    int       samples_pushed = 0;
    int       samples_taken  = 0;
    int       words_seen     = 0;
    int       range_changes  = 0;
    int       warnings_seen  = 0;
    int       settings_used  = 0;
    int       fail_count     = 0;

    adc_auto_range_monitor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic longint full_scale_mv(input int r);
        case (r)
            0:       return 6144;
            1:       return 4096;
            2:       return 2048;
            3:       return 1024;
            4:       return 512;
            default: return 256;
        endcase
    endfunction

    // Convert one sample and advance the channel's counters and range
    function automatic reading_t track_sample(input sample_t s);
        reading_t rd;
        int       ch;
        int       r;
        int       nr;
        int       nxt;
        longint   mag;
        longint   scaled;
        longint   prod;
        longint   uv;
        longint   cnt;
        ch     = s.channel;
        r      = (ch_range[ch] <= NARROWEST) ? ch_range[ch] : NARROWEST;
        mag    = s.code[15] ? 65536 - longint'(s.code) : longint'(s.code);
        scaled = mag * full_scale_mv(r);
        prod   = scaled * 1000;
        uv     = s.code[15] ? -((prod + 32767) / 32768) : prod / 32768;
        rd.channel  = s.channel;
        rd.value_uv = uv[23:0];
        rd.changed  = 1'b0;
        rd.warn     = 1'b0;
        nr = r;

        // Count overvoltage samples, warn on the eleventh and clear
        if (scaled > longint'(cfg_ov_mv) * 32768) begin
            ch_over[ch] = ch_over[ch] + 4'd1;
            if (ch_over[ch] > WARN_COUNT) begin
                rd.warn     = 1'b1;
                ch_over[ch] = '0;
            end
        end

        // Widen at once when loud, narrow after a run of quiet samples
        if (cfg_auto) begin
            cnt = (ch_quiet[ch] == 0) ? longint'(cfg_delay) : longint'(ch_quiet[ch]);
            if (scaled * 20 > 19 * full_scale_mv(nr) * 32768 && nr > 0) begin
                nr--;
                rd.changed = 1'b1;
            end
            nxt = (nr < NARROWEST) ? nr + 1 : NARROWEST;
            if (scaled * 5 < 4 * full_scale_mv(nxt) * 32768 && nr < NARROWEST) begin
                if (cnt <= 1) begin
                    nr++;
                    rd.changed = 1'b1;
                    cnt = 0;
                end else begin
                    cnt--;
                end
            end else begin
                cnt = longint'(cfg_delay);
            end
            ch_quiet[ch] = cnt[23:0];
            ch_range[ch] = nr[2:0];
        end
        rd.range_index = nr[2:0];
        return rd;
    endfunction

    // Sample driver: draw a gap per word, hold the word until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_readings.push_back(track_sample(cur_sample));
                samples_taken++;
            end
            send_next = s_tvalid && !s_tready;
            if (!send_next && sample_queue.size() > 0) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else begin
                    cur_sample = sample_queue.pop_front();
                    s_tuser   <= cur_sample.channel;
                    s_tdata   <= cur_sample.code;
                    send_next = 1'b1;
                    send_wait = send_no_idle ? 0 : $urandom_range(0, GAP_MAX);
                    if ($urandom_range(0, 39) == 0)
                        send_no_idle = !send_no_idle;
                end
            end
            s_tvalid <= send_next;
        end
    end

    // Result monitor: check each word against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                words_seen++;
                if (expected_readings.size() == 0) begin
                    $error("result word with none expected: channel %0d tdata %h",
                           m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_readings.pop_front();
                    if (m_tuser !== want.channel) begin
                        $error("out_channel: expected %0d, got %0d", want.channel, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[23:0] !== want.value_uv) begin
                        $error("value_uv: expected %0d, got %0d",
                               $signed(want.value_uv), $signed(m_tdata[23:0]));
                        fail_count++;
                    end
                    if (m_tdata[26:24] !== want.range_index) begin
                        $error("range_index: expected %0d, got %0d",
                               want.range_index, m_tdata[26:24]);
                        fail_count++;
                    end
                    if (m_tdata[27] !== want.changed) begin
                        $error("range_changed: expected %0d, got %0d",
                               want.changed, m_tdata[27]);
                        fail_count++;
                    end
                    if (m_tdata[28] !== want.warn) begin
                        $error("overvoltage_warn: expected %0d, got %0d",
                               want.warn, m_tdata[28]);
                        fail_count++;
                    end
                    if (want.changed)
                        range_changes++;
                    if (want.warn)
                        warnings_seen++;
                end
                recv_wait = recv_no_stall ? 0 : $urandom_range(0, GAP_MAX);
                if ($urandom_range(0, 39) == 0)
                    recv_no_stall = !recv_no_stall;
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $error("no word moved for %0d cycles", IDLE_LIMIT);
            $display("** adc_auto_range_monitor: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_sample(input logic [1:0] ch, input logic [15:0] code);
        sample_t s;
        s.channel = ch;
        s.code    = code;
        sample_queue.push_back(s);
        samples_pushed++;
    endtask

    // Wait for every result, then let the pipeline settle
    task automatic wait_idle();
        while (words_seen < samples_pushed)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_AUTO: cfg_auto  = val[0];
            REG_OVER: cfg_ov_mv = val[OV_W-1:0];
            default:  cfg_delay = val[DELAY_W-1:0];
        endcase
    endtask

    task automatic set_config(input logic auto_on, input int ov_mv, input int delay);
        write_reg(REG_AUTO, 32'(auto_on));
        write_reg(REG_OVER, 32'(ov_mv));
        write_reg(REG_DELAY, 32'(delay));
        settings_used++;
    endtask

    // Mix of full-range words, magnitudes scaled to each range, near full
    // scale and the end points
    function automatic logic [15:0] random_code();
        int kind;
        int mag;
        kind = $urandom_range(0, 5);
        if (kind == 0)
            return 16'($urandom());
        if (kind == 5) begin
            case ($urandom_range(0, 3))
                0:       return 16'h0000;
                1:       return 16'h7FFF;
                2:       return 16'h8000;
                default: return 16'hFFFF;
            endcase
        end
        if (kind == 4)
            mag = $urandom_range(30500, 32768);
        else
            mag = $urandom_range(0, 32768 >> $urandom_range(0, 8));
        return $urandom_range(0, 1) ? 16'(65536 - mag) : 16'(mag);
    endfunction

    initial begin
        int         p;
        int         n;
        int         ov_mv;
        int         delay;
        logic [1:0] ch;

        cfg_auto  = 1'b0;
        cfg_ov_mv = OVER_RESET;
        cfg_delay = DELAY_RESET;
        for (int i = 0; i < NUM_CH; i++) begin
            ch_range[i] = '0;
            ch_quiet[i] = '0;
            ch_over[i]  = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: code extremes at the widest range, full negative
        // scale sits exactly on the overvoltage level
        add_sample(2'd0, 16'h0000);
        add_sample(2'd1, 16'h7FFF);
        add_sample(2'd2, 16'h8000);
        add_sample(2'd3, 16'hFFFF);
        add_sample(2'd0, 16'h0001);
        add_sample(2'd1, 16'h8001);
        wait_idle();

        // Zero overvoltage level: the eleventh nonzero sample warns
        set_config(1'b0, 0, 5000);
        for (int i = 0; i < 11; i++)
            add_sample(2'd2, 16'h0001);
        add_sample(2'd2, 16'h0000);
        wait_idle();

        // Zero delay: narrow on every quiet sample down to the narrowest,
        // then widen at once on full-scale samples
        set_config(1'b1, 6144, 0);
        for (int i = 0; i < 6; i++)
            add_sample(2'd3, 16'h0010);
        add_sample(2'd3, 16'h7FFF);
        add_sample(2'd3, 16'h8000);
        wait_idle();

        // Random phases over a spread of register settings
        ch = '0;
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0: begin
                    ov_mv = 8191;
                    delay = 24'hFFFFFF;
                end
                1: begin
                    ov_mv = $urandom_range(0, 300);
                    delay = 1;
                end
                2: begin
                    ov_mv = $urandom_range(0, 8191);
                    delay = $urandom_range(2, 12);
                end
                default: begin
                    ov_mv = $urandom_range(0, 1000);
                    delay = $urandom_range(1, 40);
                end
            endcase
            set_config((p % 4) != 3 || p == 3 ? ((p % 4) != 3) : 1'b1, ov_mv, delay);
            for (n = 0; n < PHASE_SAMPLES; n++) begin
                if ($urandom_range(0, 1) == 0)
                    ch = 2'($urandom_range(0, NUM_CH - 1));
                add_sample(ch, random_code());
            end
            wait_idle();
        end
        repeat (6) @(posedge aclk);

        if (expected_readings.size() != 0) begin
            $error("%0d predicted results never arrived", expected_readings.size());
            fail_count++;
        end
        $display("Checked %0d result words from %0d samples over %0d register settings.",
                 words_seen, samples_taken, settings_used);
        $display("Words carried %0d range switches and %0d overvoltage warnings.",
                 range_changes, warnings_seen);
        if (fail_count == 0)
            $display("** adc_auto_range_monitor: PASSED **");
        else
            $display("** adc_auto_range_monitor: FAILED **");
        $finish;
    end

endmodule
